// ===== rtl/smvm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smvm_pkg
// types and constants shared by the sparse matrix-vector multiply modules
// ----------------------------------------------------------------------------
package smvm_pkg;

    localparam int ACTION_W = 2;
    localparam int COLUMN_W = 12;
    localparam int VALUE_W  = 32;
    localparam int ROW_W    = 16;
    localparam int ACC_W    = 48;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 11'd1024;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

    localparam logic signed [VALUE_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] SUM_MIN = 32'sh8000_0000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_NONZERO = 2'd1,
        ACT_END_ROW = 2'd2,
        ACT_RESTART = 2'd3
    } t_action;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic clear;
    } t_mac_ctrl;

endpackage
`default_nettype wire

// ===== rtl/sparse_matrix_vector_multiply.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply
// csr sparse matrix times dense vector, signed fixed point
//
// A beat is accepted on a rising edge with i_start high and o_busy low.
// Actions: load vector element, nonzero entry, end of row, restart.
// Loads, end of row and restart leave o_busy low.
// A nonzero inside the vector runs in three steps: store read, registered
// multiply, saturating accumulate; o_busy is high for the last two steps.
// A nonzero outside the vector is dropped and o_busy stays low.
// End of row puts row index, saturated sum and flag on the outputs in the
// next cycle with o_strobe high for that one cycle; the receiver cannot
// stall, so results are never held.
// The vector store is a single-port ram of MAX_COLUMNS words, undefined
// until written. Column count is written through i_cfg_wr_en; the user must
// do so only while the block is idle, which the block itself does not enforce.
// Reset clears the row counter, accumulator and handshake state and sets
// the column count to 1024.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply #(
    parameter int MAX_COLUMNS   = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic [smvm_pkg::ACTION_W-1:0]         i_action,
    input  wire logic [smvm_pkg::COLUMN_W-1:0]         i_column,
    input  wire logic signed [smvm_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [smvm_pkg::CFG_W-1:0]            i_cfg_wr_data,
    output logic                                       o_strobe,
    output logic [smvm_pkg::ROW_W-1:0]                 o_row_index,
    output logic signed [smvm_pkg::VALUE_W-1:0]        o_row_sum,
    output logic                                       o_saturated
);

    import smvm_pkg::*;

    localparam int ADDR_W = $clog2(MAX_COLUMNS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_ACC  = 3'b100
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CFG_W-1:0]         r_column_count;
    logic [ROW_W-1:0]         r_row_counter;
    logic [ROW_W-1:0]         n_row_counter;
    logic signed [VALUE_W-1:0] r_value;
    logic                     r_strobe;
    logic                     n_strobe;
    logic [ROW_W-1:0]         r_row_index;
    logic signed [VALUE_W-1:0] r_row_sum;
    logic                     r_saturated;

    logic                     w_accept;
    logic [31:0]              w_col_wide;
    logic [ADDR_W-1:0]        w_addr;
    logic                     w_in_store;
    logic                     w_in_vector;
    logic                     w_ram_we;
    logic [VALUE_W-1:0]       w_rd_data;
    logic signed [ACC_W-1:0]  w_acc;
    logic                     w_sum_fits;
    logic signed [VALUE_W-1:0] w_sum_sat;
    logic                     w_row_done;
    t_mac_ctrl                w_mac_ctrl;

    assign w_accept    = i_start & ~o_busy;
    assign w_col_wide  = {{(32-COLUMN_W){1'b0}}, i_column};
    assign w_addr      = w_col_wide[ADDR_W-1:0];
    assign w_in_store  = w_col_wide < 32'(MAX_COLUMNS);
    assign w_in_vector = w_in_store & ({1'b0, r_column_count} > i_column);

    assign w_sum_fits = (&w_acc[ACC_W-1:VALUE_W-1]) | ~(|w_acc[ACC_W-1:VALUE_W-1]);
    assign w_sum_sat  = w_sum_fits ? w_acc[VALUE_W-1:0] : (w_acc[ACC_W-1] ? SUM_MIN : SUM_MAX);

    always_comb begin
        n_state           = r_state;
        n_row_counter     = r_row_counter;
        n_strobe          = 1'b0;
        w_ram_we          = 1'b0;
        w_row_done        = 1'b0;
        w_mac_ctrl.mul_en = 1'b0;
        w_mac_ctrl.acc_en = 1'b0;
        w_mac_ctrl.clear  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_action'(i_action))
                        ACT_LOAD: begin
                            w_ram_we = w_in_store;
                        end
                        ACT_NONZERO: begin
                            if (w_in_vector) begin
                                n_state = S_READ;
                            end
                        end
                        ACT_END_ROW: begin
                            w_row_done       = 1'b1;
                            n_strobe         = 1'b1;
                            n_row_counter    = r_row_counter + 1'b1;
                            w_mac_ctrl.clear = 1'b1;
                        end
                        ACT_RESTART: begin
                            n_row_counter    = '0;
                            w_mac_ctrl.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                w_mac_ctrl.mul_en = 1'b1;
                n_state           = S_ACC;
            end
            S_ACC: begin
                w_mac_ctrl.acc_en = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_column_count <= COLUMN_COUNT_RESET;
            r_row_counter  <= '0;
            r_strobe       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_row_counter <= n_row_counter;
            r_strobe      <= n_strobe;
            if (i_cfg_wr_en) begin
                r_column_count <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_value;
        end
        if (w_row_done) begin
            r_row_index <= r_row_counter;
            r_row_sum   <= w_sum_sat;
            r_saturated <= ~w_sum_fits;
        end
    end

    smvm_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(MAX_COLUMNS)
    ) u_vector_store (
        .i_clk    (i_clk),
        .i_wr_en  (w_ram_we),
        .i_addr   (w_addr),
        .i_wr_data(i_value),
        .o_rd_data(w_rd_data)
    );

    smvm_mac #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_mac_ctrl),
        .i_matrix_value(r_value),
        .i_vector_value(signed'(w_rd_data)),
        .o_acc         (w_acc)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_row_index = r_row_index;
    assign o_row_sum   = r_row_sum;
    assign o_saturated = r_saturated;

endmodule
`default_nettype wire

// ===== rtl/smvm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smvm_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module smvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/smvm_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smvm_mac
// registered multiply, floor shift, saturating 48-bit row accumulator
// ----------------------------------------------------------------------------
module smvm_mac #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire smvm_pkg::t_mac_ctrl                    i_ctrl,
    input  wire logic signed [smvm_pkg::VALUE_W-1:0]    i_matrix_value,
    input  wire logic signed [smvm_pkg::VALUE_W-1:0]    i_vector_value,
    output logic signed      [smvm_pkg::ACC_W-1:0]      o_acc
);

    import smvm_pkg::*;

    logic signed [PROD_W-1:0] r_product;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    logic signed [PROD_W-1:0] w_shifted;
    logic signed [ACC_W-1:0]  w_prod_sat;
    logic signed [ACC_W:0]    w_sum;
    logic                     w_prod_fits;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_product <= i_matrix_value * i_vector_value;
        end
    end

    // arithmetic shift gives rounding toward minus infinity
    assign w_shifted   = r_product >>> FRACTION_BITS;
    assign w_prod_fits = (&w_shifted[PROD_W-1:ACC_W-1]) | ~(|w_shifted[PROD_W-1:ACC_W-1]);
    assign w_prod_sat  = w_prod_fits ? w_shifted[ACC_W-1:0]
                                     : (w_shifted[PROD_W-1] ? ACC_MIN : ACC_MAX);
    assign w_sum       = {r_acc[ACC_W-1], r_acc} + {w_prod_sat[ACC_W-1], w_prod_sat};

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.acc_en) begin
            if (w_sum[ACC_W] == w_sum[ACC_W-1]) begin
                n_acc = w_sum[ACC_W-1:0];
            end else begin
                n_acc = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire
